/* hw/rtl/ipsc_pkg.sv */
package ipsc_pkg;

    // Timebase and counter sizing
    localparam int TICKS_PER_SECOND = 5;
    localparam int SECONDS_WIDTH    = 16;
    localparam int TICK_W           = $clog2(TICKS_PER_SECOND + 1);
    localparam int THRESH_W         = 16;
    localparam int CMP_W            = (SECONDS_WIDTH > THRESH_W) ? SECONDS_WIDTH : THRESH_W;

    // Configuration port sizing
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed levels
    localparam logic [7:0] DIM_LEVEL           = 8'd12;
    localparam logic [7:0] BACKLIGHT_OFF       = 8'd0;
    localparam logic [7:0] FULL_BRIGHTNESS_RST = 8'd255;
    localparam logic [SECONDS_WIDTH-1:0] SECONDS_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_AFTER        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_OFF_AFTER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIBERNATE_AFTER  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_BRIGHTNESS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_WAKES      = 3'd4;

    typedef enum logic [1:0] {
        MODE_ACTIVE    = 2'd0,
        MODE_DIM       = 2'd1,
        MODE_STANDBY   = 2'd2,
        MODE_HIBERNATE = 2'd3
    } t_power_mode;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ACTIVITY  = 3'd1,
        OP_STANDBY   = 3'd2,
        OP_WAKE_PIN  = 3'd3,
        OP_HIBERNATE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        NOTICE_NONE  = 2'd0,
        NOTICE_ENTER = 2'd1,
        NOTICE_LEAVE = 2'd2
    } t_notice;

    typedef struct packed {
        logic [THRESH_W-1:0] dim_after_seconds;
        logic [THRESH_W-1:0] screen_off_after_seconds;
        logic [THRESH_W-1:0] hibernate_after_seconds;
        logic [7:0]          full_brightness;
        logic                touch_wakes;
    } t_cfg;

    typedef struct packed {
        t_power_mode              mode;
        logic [TICK_W-1:0]        tick_fraction;
        logic [SECONDS_WIDTH-1:0] elapsed_seconds;
        logic [7:0]               backlight;
    } t_state;

endpackage

/* hw/rtl/ipsc_cfg_regs.sv */
module ipsc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ipsc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ipsc_pkg::t_cfg                     o_cfg
);

    ipsc_pkg::t_cfg r_cfg;

    // Always able to take a register write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Hold register values; update the addressed one on a write, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_after_seconds        <= ipsc_pkg::THRESH_W'(30);
            r_cfg.screen_off_after_seconds <= ipsc_pkg::THRESH_W'(60);
            r_cfg.hibernate_after_seconds  <= '0;
            r_cfg.full_brightness          <= ipsc_pkg::FULL_BRIGHTNESS_RST;
            r_cfg.touch_wakes              <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ipsc_pkg::REG_DIM_AFTER:
                    r_cfg.dim_after_seconds <= i_cfg_data[ipsc_pkg::THRESH_W-1:0];
                ipsc_pkg::REG_SCREEN_OFF_AFTER:
                    r_cfg.screen_off_after_seconds <= i_cfg_data[ipsc_pkg::THRESH_W-1:0];
                ipsc_pkg::REG_HIBERNATE_AFTER:
                    r_cfg.hibernate_after_seconds <= i_cfg_data[ipsc_pkg::THRESH_W-1:0];
                ipsc_pkg::REG_FULL_BRIGHTNESS:
                    r_cfg.full_brightness <= i_cfg_data[7:0];
                ipsc_pkg::REG_TOUCH_WAKES:
                    r_cfg.touch_wakes <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ipsc_step.sv */
module ipsc_step (
    input  ipsc_pkg::t_state    i_state,
    input  ipsc_pkg::t_cfg      i_cfg,
    input  logic [2:0]          i_op,
    input  logic                i_wake_from_touch,
    output ipsc_pkg::t_state    o_state,
    output ipsc_pkg::t_notice   o_notice,
    output logic                o_save
);

    logic [ipsc_pkg::TICK_W-1:0]        frac_inc;
    logic [ipsc_pkg::SECONDS_WIDTH-1:0] elapsed_tick;
    logic [ipsc_pkg::TICK_W-1:0]        frac_tick;
    logic [ipsc_pkg::CMP_W-1:0]         elapsed_cmp;
    logic                               reach_dim;
    logic                               reach_off;
    logic                               reach_hib;

    // Advance the tick counter and roll whole seconds, saturating
    always_comb begin
        frac_inc     = i_state.tick_fraction + 1'b1;
        frac_tick    = frac_inc;
        elapsed_tick = i_state.elapsed_seconds;
        if (frac_inc >= ipsc_pkg::TICK_W'(ipsc_pkg::TICKS_PER_SECOND)) begin
            frac_tick = '0;
            if (i_state.elapsed_seconds != ipsc_pkg::SECONDS_MAX) begin
                elapsed_tick = i_state.elapsed_seconds + 1'b1;
            end
        end
        elapsed_cmp = ipsc_pkg::CMP_W'(elapsed_tick);
        reach_dim   = elapsed_cmp >= ipsc_pkg::CMP_W'(i_cfg.dim_after_seconds);
        reach_off   = elapsed_cmp >= ipsc_pkg::CMP_W'(i_cfg.screen_off_after_seconds);
        reach_hib   = (i_cfg.hibernate_after_seconds != '0) &&
                      (elapsed_cmp >= ipsc_pkg::CMP_W'(i_cfg.hibernate_after_seconds));
    end

    // Apply one event to the power state
    always_comb begin
        o_state  = i_state;
        o_notice = ipsc_pkg::NOTICE_NONE;
        o_save   = 1'b0;
        if (i_state.mode != ipsc_pkg::MODE_HIBERNATE) begin
            case (i_op)
                ipsc_pkg::OP_TICK: begin
                    o_state.tick_fraction   = frac_tick;
                    o_state.elapsed_seconds = elapsed_tick;
                    case (i_state.mode)
                        ipsc_pkg::MODE_ACTIVE: begin
                            if (reach_dim) begin
                                o_state.mode      = ipsc_pkg::MODE_DIM;
                                o_state.backlight = ipsc_pkg::DIM_LEVEL;
                            end
                        end
                        ipsc_pkg::MODE_DIM: begin
                            if (!reach_dim) begin
                                o_state.mode      = ipsc_pkg::MODE_ACTIVE;
                                o_state.backlight = i_cfg.full_brightness;
                            end else if (reach_off) begin
                                o_state.mode            = ipsc_pkg::MODE_STANDBY;
                                o_state.backlight       = ipsc_pkg::BACKLIGHT_OFF;
                                o_state.tick_fraction   = '0;
                                o_state.elapsed_seconds = '0;
                                o_notice                = ipsc_pkg::NOTICE_ENTER;
                            end
                        end
                        default: begin
                            if (reach_hib) begin
                                o_state.mode      = ipsc_pkg::MODE_HIBERNATE;
                                o_state.backlight = ipsc_pkg::BACKLIGHT_OFF;
                                o_save            = 1'b1;
                            end
                        end
                    endcase
                end
                ipsc_pkg::OP_ACTIVITY: begin
                    if (i_state.mode inside {ipsc_pkg::MODE_ACTIVE, ipsc_pkg::MODE_DIM}) begin
                        o_state.tick_fraction   = '0;
                        o_state.elapsed_seconds = '0;
                        o_state.mode            = ipsc_pkg::MODE_ACTIVE;
                        if (i_state.mode == ipsc_pkg::MODE_DIM) begin
                            o_state.backlight = i_cfg.full_brightness;
                        end
                    end
                end
                ipsc_pkg::OP_STANDBY: begin
                    if (i_state.mode inside {ipsc_pkg::MODE_ACTIVE, ipsc_pkg::MODE_DIM}) begin
                        o_state.tick_fraction   = '0;
                        o_state.elapsed_seconds = ipsc_pkg::SECONDS_MAX;
                    end
                end
                ipsc_pkg::OP_WAKE_PIN: begin
                    if ((i_state.mode == ipsc_pkg::MODE_STANDBY) &&
                        (!i_wake_from_touch || i_cfg.touch_wakes)) begin
                        o_state.mode            = ipsc_pkg::MODE_ACTIVE;
                        o_state.tick_fraction   = '0;
                        o_state.elapsed_seconds = '0;
                        o_state.backlight       = i_cfg.full_brightness;
                        o_notice                = ipsc_pkg::NOTICE_LEAVE;
                    end
                end
                ipsc_pkg::OP_HIBERNATE: begin
                    o_state.mode      = ipsc_pkg::MODE_HIBERNATE;
                    o_state.backlight = ipsc_pkg::BACKLIGHT_OFF;
                    o_save            = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/idle_power_state_controller.sv */
// Idle power state controller: active, dim, standby and hibernate.
// Request channel: i_in_valid / o_in_stall with i_op and i_wake_from_touch;
// a request is taken at a clock edge with valid high and stall low.
// Result channel: o_out_valid / i_out_stall; one result per request, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write registers only while no request is
// outstanding.
// The result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle; the state update and the compare
// against the thresholds fit between the state register and the result
// register, so each request sees the state left by the one before it.
// When the receiver stalls, the result register holds its contents and
// o_in_stall rises, so no further request is taken until the result leaves.
// Reset (synchronous, active low) returns the registers to their defaults,
// the mode to active at full brightness, clears the idle counters and
// empties the result register.
module idle_power_state_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_op,
    input  logic                              i_wake_from_touch,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_power_state,
    output logic [7:0]                        o_backlight_level,
    output logic                              o_panel_blanked,
    output logic [1:0]                        o_standby_notice,
    output logic                              o_save_session,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ipsc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ipsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    ipsc_pkg::t_cfg    cfg;
    ipsc_pkg::t_state  r_state;
    ipsc_pkg::t_state  n_state;
    ipsc_pkg::t_notice n_notice;
    logic              n_save;
    logic              in_take;
    logic              r_out_valid;
    logic [1:0]        r_power_state;
    logic [7:0]        r_backlight;
    logic              r_blanked;
    logic [1:0]        r_notice;
    logic              r_save;

    ipsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ipsc_step u_step (
        .i_state           (r_state),
        .i_cfg             (cfg),
        .i_op              (i_op),
        .i_wake_from_touch (i_wake_from_touch),
        .o_state           (n_state),
        .o_notice          (n_notice),
        .o_save            (n_save)
    );

    // Stall the request side only while a result is held back
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    // Advance the power state on each request taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= ipsc_pkg::MODE_ACTIVE;
            r_state.tick_fraction   <= '0;
            r_state.elapsed_seconds <= '0;
            r_state.backlight       <= ipsc_pkg::FULL_BRIGHTNESS_RST;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Track result occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result fields
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_power_state <= n_state.mode;
            r_backlight   <= n_state.backlight;
            r_blanked     <= (n_state.mode == ipsc_pkg::MODE_STANDBY) ||
                             (n_state.mode == ipsc_pkg::MODE_HIBERNATE);
            r_notice      <= n_notice;
            r_save        <= n_save;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_power_state     = r_power_state;
    assign o_backlight_level = r_backlight;
    assign o_panel_blanked   = r_blanked;
    assign o_standby_notice  = r_notice;
    assign o_save_session    = r_save;

    // Hibernate is left only through reset
    a_hibernate_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == ipsc_pkg::MODE_HIBERNATE) |=>
        (r_state.mode == ipsc_pkg::MODE_HIBERNATE))
        else $error("hibernate state was left without reset");

    // A save strobe only comes with a dark panel in hibernate
    a_save_in_hibernate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_save_session) |->
        ((o_power_state == ipsc_pkg::MODE_HIBERNATE) &&
         (o_backlight_level == ipsc_pkg::BACKLIGHT_OFF)))
        else $error("save strobe outside hibernate entry");

    // Entering standby reports the standby mode with a blanked panel
    a_enter_standby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_standby_notice == ipsc_pkg::NOTICE_ENTER)) |->
        ((o_power_state == ipsc_pkg::MODE_STANDBY) && o_panel_blanked &&
         (r_state.mode != ipsc_pkg::MODE_ACTIVE || $past(in_take))))
        else $error("standby entry reported with wrong state");

endmodule
